FILE: rtl/core/utf8ss_pkg.sv
`timescale 1ns / 1ps

package utf8ss_pkg;

    localparam int MaxResults = 4;
    localparam int CountWidth = $clog2(MaxResults + 1);
    localparam int IndexWidth = $clog2(MaxResults);

    localparam logic [7:0] ChrEsc      = 8'h1b;
    localparam logic [7:0] ChrBracket  = 8'h5b;
    localparam logic [7:0] ChrTab      = 8'h09;
    localparam logic [7:0] ChrLf       = 8'h0a;
    localparam logic [7:0] ChrCr       = 8'h0d;
    localparam logic [7:0] ChrSpace    = 8'h20;
    localparam logic [7:0] ChrQuestion = 8'h3f;
    localparam logic [7:0] FinalLow    = 8'h40;
    localparam logic [7:0] FinalHigh   = 8'h7e;
    localparam logic [7:0] Lead2Low    = 8'hc2;
    localparam logic [7:0] Lead2High   = 8'hdf;
    localparam logic [7:0] Lead3Low    = 8'he0;
    localparam logic [7:0] Lead3High   = 8'hef;
    localparam logic [7:0] Lead4Low    = 8'hf0;
    localparam logic [7:0] Lead4High   = 8'hf4;
    localparam logic [7:0] LeadSurr    = 8'hed;
    localparam logic [7:0] ContMask    = 8'hc0;
    localparam logic [7:0] ContTag     = 8'h80;
    localparam logic [7:0] ContA0      = 8'ha0;
    localparam logic [7:0] Cont8f      = 8'h8f;
    localparam logic [7:0] Cont90      = 8'h90;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       eot;
    } utf8ss_result_t;

    typedef utf8ss_result_t [MaxResults-1:0] utf8ss_burst_t;

    // Everything one byte produces, handed from the decoder to the output buffer.
    typedef struct packed {
        utf8ss_burst_t         results;
        logic [CountWidth-1:0] count;
    } utf8ss_step_t;

endpackage

FILE: rtl/core/utf8_sanitize_strip_csi_core.sv
`timescale 1ns / 1ps

// Streaming UTF-8 sanitizer that also strips ESC '[' control sequences. Each
// input transaction carries one byte and a final_byte flag; it yields zero to
// four output transactions, and the last text byte always yields at least one,
// flagged end_of_text (a bare end marker with byte_present low if nothing else
// is left). A byte is decoded in the cycle it is accepted and its results go
// into a four-entry output buffer that drains one transaction per cycle while
// out_ready is high, so the block takes one byte per cycle while each byte
// gives at most one result; a byte with more results holds the input until
// all but its last have left, as the single output port sets the pace. Output
// backpressure stalls input once the buffer holds more than the outgoing one.

module utf8_sanitize_strip_csi_core
    import utf8ss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_present,
    output logic       end_of_text
);

    utf8ss_step_t step;
    logic         accept;

    assign accept = in_valid && in_ready;

    utf8ss_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .step       (step)
    );

    utf8ss_burst u_burst (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .step         (step),
        .room         (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_present (byte_present),
        .end_of_text  (end_of_text)
    );

endmodule

FILE: rtl/core/utf8ss_step.sv
`timescale 1ns / 1ps

module utf8ss_step
    import utf8ss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [7:0]   in_byte,
    input  logic         final_byte,
    output utf8ss_step_t step
);

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       esc;
        logic       hold;
        logic [2:0] len;
    } fresh_t;

    logic [7:0] held0_reg, held1_reg, held2_reg;
    logic [7:0] held0_next, held1_next, held2_next;
    logic [1:0] held_count_reg, held_count_next;
    logic [2:0] needed_len_reg, needed_len_next;
    logic       esc_reg, esc_next;
    logic       csi_reg, csi_next;

    fresh_t                f;
    logic                  cont_ok;
    logic                  do_fresh;
    logic [IndexWidth-1:0] pos;
    logic [IndexWidth-1:0] last;
    utf8ss_burst_t         res;
    logic [CountWidth-1:0] n;

    function automatic fresh_t fresh(input logic [7:0] b, input logic fin);
        fresh_t r;
        r = '0;
        if (b < ContTag) begin
            if (b == ChrEsc) begin
                if (fin) begin
                    r.emit = 1'b1;
                    r.data = ChrSpace;
                end
                else begin
                    r.esc = 1'b1;
                end
            end
            else if (b == ChrTab || b == ChrLf || b == ChrCr || b >= ChrSpace) begin
                r.emit = 1'b1;
                r.data = b;
            end
            else begin
                r.emit = 1'b1;
                r.data = ChrSpace;
            end
        end
        else begin
            if (b >= Lead2Low && b <= Lead2High) begin
                r.len = 3'd2;
            end
            else if (b >= Lead3Low && b <= Lead3High) begin
                r.len = 3'd3;
            end
            else if (b >= Lead4Low && b <= Lead4High) begin
                r.len = 3'd4;
            end
            if (r.len == 3'd0 || fin) begin
                r.emit = 1'b1;
                r.data = ChrQuestion;
            end
            else begin
                r.hold = 1'b1;
            end
        end
        return r;
    endfunction

    assign f = fresh(in_byte, final_byte);

    // The second byte of a sequence also carries the range limits that rule out
    // overlong forms, surrogates and values above U+10FFFF.
    always_comb
    begin
        cont_ok = ((in_byte & ContMask) == ContTag);
        if (held_count_reg == 2'd1) begin
            if (held0_reg == Lead3Low && in_byte < ContA0) begin
                cont_ok = 1'b0;
            end
            if (held0_reg == LeadSurr && in_byte >= ContA0) begin
                cont_ok = 1'b0;
            end
            if (held0_reg == Lead4Low && in_byte < Cont90) begin
                cont_ok = 1'b0;
            end
            if (held0_reg == Lead4High && in_byte > Cont8f) begin
                cont_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        res             = '0;
        n               = '0;
        do_fresh        = 1'b0;
        pos             = '0;
        last            = '0;
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        held2_next      = held2_reg;
        held_count_next = held_count_reg;
        needed_len_next = needed_len_reg;
        esc_next        = esc_reg;
        csi_next        = csi_reg;

        if (csi_reg) begin
            if (in_byte >= FinalLow && in_byte <= FinalHigh) begin
                csi_next = 1'b0;
            end
        end
        else if (esc_reg) begin
            esc_next = 1'b0;
            if (in_byte == ChrBracket) begin
                csi_next = 1'b1;
            end
            else begin
                res[0]   = '{data: ChrSpace, present: 1'b1, eot: 1'b0};
                n        = CountWidth'(1);
                pos      = IndexWidth'(1);
                do_fresh = 1'b1;
            end
        end
        else if (held_count_reg != 2'd0) begin
            if (cont_ok && ({1'b0, held_count_reg} + 3'd1) == needed_len_reg) begin
                res[0] = '{data: held0_reg, present: 1'b1, eot: 1'b0};
                if (held_count_reg >= 2'd2) begin
                    res[1] = '{data: held1_reg, present: 1'b1, eot: 1'b0};
                end
                if (held_count_reg == 2'd3) begin
                    res[2] = '{data: held2_reg, present: 1'b1, eot: 1'b0};
                end
                res[held_count_reg] = '{data: in_byte, present: 1'b1, eot: 1'b0};
                n = CountWidth'(held_count_reg) + CountWidth'(1);
                held_count_next = 2'd0;
                needed_len_next = 3'd0;
            end
            else if (cont_ok && !final_byte && held_count_reg != 2'd3) begin
                if (held_count_reg == 2'd1) begin
                    held1_next = in_byte;
                end
                else begin
                    held2_next = in_byte;
                end
                held_count_next = held_count_reg + 2'd1;
            end
            else begin
                // Every held byte turns into '?', then the current byte starts over.
                for (int i = 0; i < 3; i++) begin
                    if (i < int'(held_count_reg)) begin
                        res[i] = '{data: ChrQuestion, present: 1'b1, eot: 1'b0};
                    end
                end
                n               = CountWidth'(held_count_reg);
                pos             = held_count_reg;
                held_count_next = 2'd0;
                needed_len_next = 3'd0;
                do_fresh        = 1'b1;
            end
        end
        else begin
            do_fresh = 1'b1;
        end

        if (do_fresh) begin
            if (f.emit) begin
                res[pos] = '{data: f.data, present: 1'b1, eot: 1'b0};
                n        = CountWidth'(pos) + CountWidth'(1);
            end
            if (f.esc) begin
                esc_next = 1'b1;
            end
            if (f.hold) begin
                held0_next      = in_byte;
                held_count_next = 2'd1;
                needed_len_next = f.len;
            end
        end

        if (final_byte) begin
            held_count_next = 2'd0;
            needed_len_next = 3'd0;
            esc_next        = 1'b0;
            csi_next        = 1'b0;
            if (n == '0) begin
                res[0] = '{data: 8'h00, present: 1'b0, eot: 1'b1};
                n      = CountWidth'(1);
            end
            else begin
                last          = IndexWidth'(n - CountWidth'(1));
                res[last].eot = 1'b1;
            end
        end
    end

    assign step.results = res;
    assign step.count   = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_count_reg <= 2'd0;
            needed_len_reg <= 3'd0;
            esc_reg        <= 1'b0;
            csi_reg        <= 1'b0;
        end
        else if (accept) begin
            held_count_reg <= held_count_next;
            needed_len_reg <= needed_len_next;
            esc_reg        <= esc_next;
            csi_reg        <= csi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            held2_reg <= held2_next;
        end
    end

endmodule

FILE: rtl/core/utf8ss_burst.sv
`timescale 1ns / 1ps

module utf8ss_burst
    import utf8ss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  utf8ss_step_t step,
    output logic         room,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_byte,
    output logic         byte_present,
    output logic         end_of_text
);

    utf8ss_burst_t         res_reg;
    logic [CountWidth-1:0] remain_reg;
    logic [IndexWidth-1:0] idx_reg;
    logic                  take;
    utf8ss_result_t        cur;

    assign out_valid = (remain_reg != '0);
    assign take      = out_valid && out_ready;
    // A new byte may load as soon as the last buffered result leaves.
    assign room      = (remain_reg == '0) || (remain_reg == CountWidth'(1) && out_ready);

    assign cur          = res_reg[idx_reg];
    assign out_byte     = cur.data;
    assign byte_present = cur.present;
    assign end_of_text  = cur.eot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            remain_reg <= '0;
            idx_reg    <= '0;
        end
        else if (load) begin
            remain_reg <= step.count;
            idx_reg    <= '0;
        end
        else if (take) begin
            remain_reg <= remain_reg - CountWidth'(1);
            idx_reg    <= idx_reg + IndexWidth'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg <= step.results;
        end
    end

endmodule

FILE: test/utf8_sanitize_strip_csi_core_test.sv
`timescale 1ns / 1ps

import utf8ss_pkg::*;

// Predicts the sanitized text and holds the results that the core still owes.
class sanitized_text_board;
    utf8ss_result_t owed_q[$];
    logic [7:0]     partial_seq[3];
    int unsigned    partial_count = 0;
    int unsigned    seq_len = 0;
    bit             esc_seen = 1'b0;
    bit             dropping_csi = 1'b0;

    function int outstanding();
        return owed_q.size();
    endfunction

    function void push_byte(logic [7:0] value);
        utf8ss_result_t r;
        r.data = value;
        r.present = 1'b1;
        r.eot = 1'b0;
        owed_q.insert(owed_q.size(), r);
    endfunction

    // A byte seen with no UTF-8 sequence or escape in progress.
    function void start_fresh(logic [7:0] value, logic last);
        int unsigned len;
        len = 0;
        if (value < ContTag) begin
            if (value == ChrEsc) begin
                if (last)
                    push_byte(ChrSpace);
                else
                    esc_seen = 1'b1;
            end
            else if (value == ChrTab || value == ChrLf || value == ChrCr || value >= ChrSpace)
                push_byte(value);
            else
                push_byte(ChrSpace);
            return;
        end
        if (value >= Lead2Low && value <= Lead2High)
            len = 2;
        else if (value >= Lead3Low && value <= Lead3High)
            len = 3;
        else if (value >= Lead4Low && value <= Lead4High)
            len = 4;
        if (len == 0 || last) begin
            push_byte(ChrQuestion);
        end
        else begin
            partial_seq[0] = value;
            partial_count = 1;
            seq_len = len;
        end
    endfunction

    // The second byte also rules out overlong forms, surrogates and code points above U+10FFFF.
    function bit continues(logic [7:0] value);
        logic [7:0] lead;
        if ((value & ContMask) != ContTag)
            return 1'b0;
        if (partial_count != 1)
            return 1'b1;
        lead = partial_seq[0];
        if (lead == Lead3Low && value < ContA0)
            return 1'b0;
        if (lead == LeadSurr && value >= ContA0)
            return 1'b0;
        if (lead == Lead4Low && value < Cont90)
            return 1'b0;
        if (lead == Lead4High && value > Cont8f)
            return 1'b0;
        return 1'b1;
    endfunction

    function void note_input(logic [7:0] value, logic last);
        int owed_before;
        bit ok;
        utf8ss_result_t marker;
        owed_before = owed_q.size();
        if (dropping_csi) begin
            if (value >= FinalLow && value <= FinalHigh)
                dropping_csi = 1'b0;
        end
        else if (esc_seen) begin
            esc_seen = 1'b0;
            if (value == ChrBracket) begin
                dropping_csi = 1'b1;
            end
            else begin
                push_byte(ChrSpace);
                start_fresh(value, last);
            end
        end
        else if (partial_count != 0) begin
            ok = continues(value);
            if (ok && partial_count + 1 == seq_len) begin
                for (int i = 0; i < partial_count; i++)
                    push_byte(partial_seq[i]);
                push_byte(value);
                partial_count = 0;
                seq_len = 0;
            end
            else if (ok && !last && partial_count < 3) begin
                partial_seq[partial_count] = value;
                partial_count++;
            end
            else begin
                for (int i = 0; i < partial_count; i++)
                    push_byte(ChrQuestion);
                partial_count = 0;
                seq_len = 0;
                start_fresh(value, last);
            end
        end
        else begin
            start_fresh(value, last);
        end

        if (last) begin
            partial_count = 0;
            seq_len = 0;
            esc_seen = 1'b0;
            dropping_csi = 1'b0;
            if (owed_q.size() == owed_before) begin
                marker.data = 8'h00;
                marker.present = 1'b0;
                marker.eot = 1'b1;
                owed_q.insert(owed_q.size(), marker);
            end
            else begin
                owed_q[owed_q.size() - 1].eot = 1'b1;
            end
        end
    endfunction

    // Returns an empty string when the transaction matches the oldest owed result.
    function string check_result(logic [7:0] data, logic present, logic eot);
        utf8ss_result_t want;
        string diff;
        diff = "";
        if (owed_q.size() == 0)
            return $sformatf("output with nothing owed: out_byte %02h byte_present %0b end_of_text %0b",
                             data, present, eot);
        want = owed_q.pop_front();
        if (data !== want.data)
            diff = {diff, $sformatf(" out_byte %02h/%02h", data, want.data)};
        if (present !== want.present)
            diff = {diff, $sformatf(" byte_present %0b/%0b", present, want.present)};
        if (eot !== want.eot)
            diff = {diff, $sformatf(" end_of_text %0b/%0b", eot, want.eot)};
        if (diff == "")
            return "";
        return {"output differs (got/expected):", diff};
    endfunction
endclass

module utf8_sanitize_strip_csi_core_test;

    localparam int ItemTarget  = 340;
    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 16;

    localparam int ReadyFull   = 0;
    localparam int ReadyCoin   = 1;
    localparam int ReadySparse = 2;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       final_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_present;
    logic       end_of_text;

    sanitized_text_board board;
    logic [7:0]          text_q[$];
    int                  burst_left = 0;
    int                  sent_count = 0;
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  ready_mode = ReadyFull;
    int                  ready_run = 0;
    string               diff_text;

    utf8_sanitize_strip_csi_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .final_byte   (final_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_present (byte_present),
        .end_of_text  (end_of_text)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver alternates between stretches of full rate, coin-flip stalls and sparse accepts.
    always @(posedge clk)
    begin
        if (ready_run == 0) begin
            ready_mode = $urandom_range(ReadyFull, ReadySparse);
            ready_run = $urandom_range(4, 40);
        end
        else begin
            ready_run = ready_run - 1;
        end
        case (ready_mode)
            ReadyFull: out_ready <= 1'b1;
            ReadyCoin: out_ready <= $urandom_range(0, 1);
            default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            diff_text = board.check_result(out_byte, byte_present, end_of_text);
            if (diff_text != "")
                report_mismatch(diff_text);
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = 64;
                gap = 0;
            end
            else begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(1, 6);
            end
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_byte <= value;
        final_byte <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_input(value, last);
        sent_count++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic void add_text_byte(input logic [7:0] value);
        text_q.insert(text_q.size(), value);
    endfunction

    // Appends one well-formed character of the given length, often at a range boundary.
    task automatic append_utf8_char(input int len);
        logic [20:0] cp;
        bit          at_edge;
        int          pick;
        at_edge = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 3);
        case (len)
            2: begin
                cp = at_edge ? (pick[0] ? 21'h0007ff : 21'h000080)
                             : 21'($urandom_range(12'h080, 12'h7ff));
                add_text_byte({3'b110, cp[10:6]});
                add_text_byte({2'b10, cp[5:0]});
            end
            3: begin
                if (at_edge) begin
                    cp = (pick == 0) ? 21'h000800 : (pick == 1) ? 21'h00d7ff :
                         (pick == 2) ? 21'h00e000 : 21'h00ffff;
                end
                else begin
                    do
                        cp = 21'($urandom_range(16'h0800, 16'hffff));
                    while (cp >= 21'h00d800 && cp <= 21'h00dfff);
                end
                add_text_byte({4'b1110, cp[15:12]});
                add_text_byte({2'b10, cp[11:6]});
                add_text_byte({2'b10, cp[5:0]});
            end
            default: begin
                cp = at_edge ? (pick[0] ? 21'h10ffff : 21'h010000)
                             : 21'($urandom_range(21'h010000, 21'h10ffff));
                add_text_byte({5'b11110, cp[20:18]});
                add_text_byte({2'b10, cp[17:12]});
                add_text_byte({2'b10, cp[11:6]});
                add_text_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic build_random_text();
        int kind;
        int len;
        text_q.delete();
        repeat ($urandom_range(1, 6)) begin
            kind = $urandom_range(0, 99);
            if (kind < 28) begin
                repeat ($urandom_range(1, 3))
                    add_text_byte(8'($urandom_range(8'h20, 8'h7f)));
            end
            else if (kind < 36) begin
                add_text_byte(8'($urandom_range(8'h00, 8'h1f)));
            end
            else if (kind < 56) begin
                append_utf8_char($urandom_range(2, 4));
            end
            else if (kind < 68) begin
                add_text_byte(ChrEsc);
                add_text_byte(ChrBracket);
                repeat ($urandom_range(0, 3))
                    add_text_byte(8'($urandom_range(8'h20, 8'h3f)));
                // An unterminated sequence swallows whatever follows until a final byte.
                if ($urandom_range(0, 4) != 0)
                    add_text_byte(8'($urandom_range(FinalLow, FinalHigh)));
            end
            else if (kind < 73) begin
                add_text_byte(ChrEsc);
                add_text_byte(8'($urandom()));
            end
            else if (kind < 80) begin
                len = $urandom_range(2, 4);
                append_utf8_char(len);
                repeat ($urandom_range(1, len - 1))
                    void'(text_q.pop_back());
            end
            else if (kind < 90) begin
                case ($urandom_range(0, 4))
                    0: begin
                        add_text_byte(Lead3Low);
                        add_text_byte(8'($urandom_range(8'h80, 8'h9f)));
                    end
                    1: begin
                        add_text_byte(LeadSurr);
                        add_text_byte(8'($urandom_range(8'ha0, 8'hbf)));
                    end
                    2: begin
                        add_text_byte(Lead4High);
                        add_text_byte(8'($urandom_range(8'h90, 8'hbf)));
                    end
                    3: begin
                        add_text_byte(Lead4Low);
                        add_text_byte(8'($urandom_range(8'h80, 8'h8f)));
                    end
                    default: add_text_byte(8'($urandom_range(8'h80, 8'hff)));
                endcase
                repeat ($urandom_range(0, 2))
                    add_text_byte(8'($urandom_range(8'h80, 8'hbf)));
            end
            else begin
                add_text_byte(8'($urandom()));
            end
        end
    endtask

    initial
    begin
        int text_count;
        board = new();
        text_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Controls, DEL and an invalid lead as the last byte.
        text_q = '{8'h00, 8'h09, 8'h0a, 8'h0d, 8'h7f, 8'hff};
        send_text();
        // A closed control sequence, a lone ESC, then a text that stops inside a sequence.
        text_q = '{8'h1b, 8'h5b, 8'h7e, 8'h1b, 8'h41, 8'h1b, 8'h5b, 8'h31};
        send_text();
        text_q = '{8'h1b};
        send_text();
        text_q = '{8'h1b, 8'h5b};
        send_text();
        // Overlong, surrogate and out-of-range forms, a four-byte character, then a
        // sequence cut by a lead byte that is itself the last byte of the text.
        text_q = '{8'he0, 8'h80, 8'hed, 8'ha0, 8'hf4, 8'h90, 8'hf0, 8'h9f, 8'h98, 8'h80,
                   8'he2, 8'h82, 8'hc3};
        send_text();
        wait_for_drain();

        while (sent_count < ItemTarget) begin
            build_random_text();
            send_text();
            text_count++;
            if (text_count % 8 == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
